/* design/ole_pkg.sv */
// Shared types and codes for the ordered list engine.
// No dependencies; imported by the controller, datapath and top level.
package ole_pkg;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_BADPOS   = 3'd4
	} status_t;

	// Request kinds (code 7 is unused and treated as a no-op)
	localparam logic [2:0] K_INS_FRONT = 3'd0;
	localparam logic [2:0] K_INS_BACK  = 3'd1;
	localparam logic [2:0] K_INS_AT    = 3'd2;
	localparam logic [2:0] K_DEL_FRONT = 3'd3;
	localparam logic [2:0] K_DEL_BACK  = 3'd4;
	localparam logic [2:0] K_DEL_AT    = 3'd5;
	localparam logic [2:0] K_SEARCH    = 3'd6;

	// Target index chosen at load time
	typedef enum logic [1:0] {
		TGT_ZERO,
		TGT_COUNT,
		TGT_LAST,
		TGT_POS
	} tgt_t;

	// Walk performed by the datapath
	typedef enum logic [1:0] {
		M_NONE,
		M_UP,
		M_DN,
		M_SRCH
	} mode_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_DN,
		S_SRCH,
		S_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic    load;
		status_t status;
		tgt_t    tgt;
		logic    up_init;
		mode_t   mode;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic pos_gt;
		logic pos_ge;
		logic walk_done;
	} dp_stat_t;

endpackage

/* design/ole_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ole_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/ole_ctrl.sv */
// Controller FSM for the ordered list engine: decodes requests, sequences walks.
// Depends on ole_pkg.
module ole_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2:0]        kind,
	input  ole_pkg::dp_stat_t stat,
	output ole_pkg::dp_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	import ole_pkg::*;

	state_t  state_q;
	state_t  state_d;
	state_t  dec_state;
	status_t dec_status;
	tgt_t    dec_tgt;

	// request decode: full/empty checked before position
	always_comb begin
		dec_state  = S_DONE;
		dec_status = ST_OK;
		dec_tgt    = TGT_ZERO;
		if (kind inside {K_INS_FRONT, K_INS_BACK, K_INS_AT}) begin
			if (stat.full) begin
				dec_status = ST_FULL;
			end else if (kind == K_INS_AT && stat.pos_gt) begin
				dec_status = ST_BADPOS;
			end else begin
				dec_state = S_UP;
				case (kind)
					K_INS_FRONT: dec_tgt = TGT_ZERO;
					K_INS_BACK:  dec_tgt = TGT_COUNT;
					default:     dec_tgt = TGT_POS;
				endcase
			end
		end else if (kind inside {K_DEL_FRONT, K_DEL_BACK, K_DEL_AT}) begin
			if (stat.empty) begin
				dec_status = ST_EMPTY;
			end else if (kind == K_DEL_AT && stat.pos_ge) begin
				dec_status = ST_BADPOS;
			end else begin
				dec_state = S_DN;
				case (kind)
					K_DEL_FRONT: dec_tgt = TGT_ZERO;
					K_DEL_BACK:  dec_tgt = TGT_LAST;
					default:     dec_tgt = TGT_POS;
				endcase
			end
		end else if (kind == K_SEARCH) begin
			if (stat.empty) begin
				dec_status = ST_EMPTY;
			end else begin
				dec_state  = S_SRCH;
				dec_status = ST_NOTFOUND;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = dec_state;
				end
			end
			S_UP, S_DN, S_SRCH: begin
				if (stat.walk_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == S_IDLE) && start;
		cmd.status  = dec_status;
		cmd.tgt     = dec_tgt;
		cmd.up_init = (dec_state == S_UP);
		case (state_q)
			S_UP:    cmd.mode = M_UP;
			S_DN:    cmd.mode = M_DN;
			S_SRCH:  cmd.mode = M_SRCH;
			default: cmd.mode = M_NONE;
		endcase
		busy = (state_q != S_IDLE);
		done = (state_q == S_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* design/ole_dp.sv */
// Datapath for the ordered list engine: element count, walk pointers, RAM, result regs.
// Depends on ole_pkg and ole_ram.
module ole_dp #(
	parameter int CAPACITY = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic signed [31:0] value,
	input  logic [10:0]       position,
	input  ole_pkg::dp_cmd_t  cmd,
	output ole_pkg::dp_stat_t stat,
	output logic [2:0]        status,
	output logic signed [31:0] removed_value,
	output logic [9:0]        found_index,
	output logic [10:0]       count
);
	import ole_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 11) ? CW : 11;
	localparam int FW = (AW > 10) ? AW : 10;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] p_q;
	logic [AW-1:0] pa_q;
	logic          pend_q;
	logic          hit_q;
	status_t       status_q;
	logic [31:0]   val_q;
	logic [31:0]   removed_q;
	logic [AW-1:0] found_q;

	logic [PW-1:0] pos_ext;
	logic [PW-1:0] cnt_ext;
	logic [FW-1:0] found_ext;
	logic [CW-1:0] tgt_val;
	logic [CW-1:0] idx_dec;
	logic          up_issue;
	logic          dn_issue;
	logic          sr_issue;
	logic          key_hit;
	logic          take_rm;
	logic          walk_done;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	ole_ram #(
		.WIDTH (32),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign pos_ext = PW'(position);
	assign cnt_ext = PW'(cnt_q);
	assign idx_dec = idx_q - CW'(1);

	always_comb begin
		stat.full      = (cnt_q == CW'(CAPACITY));
		stat.empty     = (cnt_q == '0);
		stat.pos_gt    = (pos_ext > cnt_ext);
		stat.pos_ge    = (pos_ext >= cnt_ext);
		stat.walk_done = walk_done;
		case (cmd.tgt)
			TGT_ZERO:  tgt_val = '0;
			TGT_COUNT: tgt_val = cnt_q;
			TGT_LAST:  tgt_val = cnt_q - CW'(1);
			TGT_POS:   tgt_val = pos_ext[CW-1:0];
			default:   tgt_val = '0;
		endcase
	end

	// walk: one RAM read issued per cycle, data used the following cycle
	always_comb begin
		up_issue  = (idx_q > p_q);
		dn_issue  = (idx_q < cnt_q);
		sr_issue  = (idx_q < cnt_q) && !hit_q;
		key_hit   = (cmd.mode == M_SRCH) && pend_q && !hit_q && (ram_rdata == val_q);
		take_rm   = (cmd.mode == M_DN) && pend_q && (pa_q == p_q[AW-1:0]);
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = pa_q;
		ram_wdata = ram_rdata;
		walk_done = 1'b0;
		case (cmd.mode)
			M_UP: begin
				// move element d-1 to d, from the back toward the target
				ram_re    = up_issue;
				ram_raddr = idx_dec[AW-1:0];
				if (pend_q) begin
					ram_we = 1'b1;
				end else if (!up_issue) begin
					ram_we    = 1'b1;
					ram_waddr = p_q[AW-1:0];
					ram_wdata = val_q;
					walk_done = 1'b1;
				end
			end
			M_DN: begin
				// first read is the removed element, later reads move one place down
				ram_re = dn_issue;
				if (pend_q && !take_rm) begin
					ram_we    = 1'b1;
					ram_waddr = pa_q - AW'(1);
				end
				walk_done = !dn_issue;
			end
			M_SRCH: begin
				ram_re    = sr_issue;
				walk_done = !pend_q && !sr_issue;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			idx_q    <= '0;
			pa_q     <= '0;
			pend_q   <= 1'b0;
			hit_q    <= 1'b0;
			status_q <= ST_OK;
		end else if (cmd.load) begin
			status_q <= cmd.status;
			idx_q    <= cmd.up_init ? cnt_q : tgt_val;
			pend_q   <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			pend_q <= ram_re;
			if (ram_re) begin
				pa_q  <= idx_q[AW-1:0];
				idx_q <= (cmd.mode == M_UP) ? idx_dec : idx_q + CW'(1);
			end
			if (key_hit) begin
				hit_q    <= 1'b1;
				status_q <= ST_OK;
			end
			if (walk_done && cmd.mode == M_UP) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (walk_done && cmd.mode == M_DN) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q     <= value;
			p_q       <= tgt_val;
			removed_q <= '0;
			found_q   <= '0;
		end else begin
			if (take_rm) begin
				removed_q <= ram_rdata;
			end
			if (key_hit) begin
				found_q <= pa_q;
			end
		end
	end

	assign found_ext     = FW'(found_q);
	assign status        = status_q;
	assign removed_value = removed_q;
	assign found_index   = found_ext[9:0];
	assign count         = cnt_ext[10:0];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_wr_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CW'(ram_waddr) <= cnt_q))
		else $error("store write beyond end of list");

	a_cnt_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> $past(walk_done))
		else $error("count changed outside walk completion");

endmodule

/* design/ordered_list_engine_core.sv */
// Ordered list engine: packed list of up to CAPACITY signed 32-bit values in one RAM.
// Rejected and unused requests go straight to done; an insert at p first moves the
// elements from p onward up one place, a delete at p moves those above p down, and a
// search reads the list to a match or its end. Throughput: one transaction at a time,
// set by the one-element-per-cycle RAM walk; a new request is taken in the cycle after done.
// Async reset empties the list; the receiver cannot stall.
module ordered_list_engine_core #(
	parameter int CAPACITY = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [2:0]         kind,
	input  logic signed [31:0] value,
	input  logic [10:0]        position,
	output logic               busy,
	output logic               done,
	output logic [2:0]         status,
	output logic signed [31:0] removed_value,
	output logic [9:0]         found_index,
	output logic [10:0]        count
);
	import ole_pkg::*;

	// controller <-> datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Controller: IDLE decodes the request against full/empty/position flags, then, unless
	// it is rejected or unused, runs one walk state (shift up, shift down or search) until
	// the datapath reports the walk complete, and shows the result for one cycle.
	ole_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Datapath: element count, walk pointer, RAM with registered read,
	// and the result registers that hold steady through the done cycle.
	ole_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.value         (value),
		.position      (position),
		.cmd           (cmd),
		.stat          (stat),
		.status        (status),
		.removed_value (removed_value),
		.found_index   (found_index),
		.count         (count)
	);

	// result strobe lasts exactly one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// busy only drops right after a result was shown
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result");

	// an accepted transaction always makes the core busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

endmodule
